### rtl/core/eul_pkg.sv
// Package for the Euler rotation block: widths, CORDIC table, register indexes.
// No dependencies.
`default_nettype none
package eul_pkg;
  localparam int CordicSteps = 19;
  localparam int CoefW = 18;
  localparam int AngW = 16;
  localparam logic signed [31:0] CordicX0 = 32'sd652032874;

  typedef enum logic [1:0] {
    REG_ANGLE_A = 2'd0,
    REG_ANGLE_B = 2'd1,
    REG_ANGLE_C = 2'd2
  } reg_idx_e;

  typedef logic signed [CoefW-1:0] coef_t;

  function automatic logic signed [23:0] atan_turn(input logic [4:0] i);
    logic signed [23:0] r;
    case (i)
      5'd0: r = 24'sd2097152;
      5'd1: r = 24'sd1238021;
      5'd2: r = 24'sd654136;
      5'd3: r = 24'sd332050;
      5'd4: r = 24'sd166669;
      5'd5: r = 24'sd83416;
      5'd6: r = 24'sd41718;
      5'd7: r = 24'sd20860;
      5'd8: r = 24'sd10430;
      5'd9: r = 24'sd5215;
      5'd10: r = 24'sd2608;
      5'd11: r = 24'sd1304;
      5'd12: r = 24'sd652;
      5'd13: r = 24'sd326;
      5'd14: r = 24'sd163;
      5'd15: r = 24'sd81;
      5'd16: r = 24'sd41;
      5'd17: r = 24'sd20;
      5'd18: r = 24'sd10;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/core/eul_cordic.sv
// Iterative CORDIC sine/cosine unit, one micro-rotation per cycle.
// Depends on eul_pkg.
`default_nettype none
module eul_cordic (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [15:0]            angle_i,
  output logic                        done_o,
  output logic signed [17:0]          sin_o,
  output logic signed [17:0]          cos_o
);
  import eul_pkg::*;

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [25:0] th_q, th_d;
  logic [4:0] step_q, step_d;
  logic busy_q, busy_d, neg_q, neg_d, done_d;
  logic signed [33:0] xs, ys, xr, yr;
  logic signed [33:0] cr, sr;

  always_comb begin
    x_d = x_q; y_d = y_q; th_d = th_q; step_d = step_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    if (start_i) begin
      x_d = 34'(CordicX0);
      y_d = '0;
      th_d = 26'(signed'({1'b0, angle_i, 8'd0}));
      neg_d = 1'b0;
      if (angle_i[15:14] == 2'd1 || angle_i[15:14] == 2'd2) begin
        th_d = th_d - 26'sd8388608;
        neg_d = 1'b1;
      end else if (angle_i[15:14] == 2'd3) begin
        th_d = th_d - 26'sd16777216;
      end
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (th_q >= 0) begin
        x_d = x_q - ys; y_d = y_q + xs; th_d = th_q - 26'(atan_turn(step_q));
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; th_d = th_q + 26'(atan_turn(step_q));
      end
      step_d = step_q + 5'd1;
      if (step_q == 5'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; th_q <= th_d; neg_q <= neg_d;
  end

  always_comb begin
    xr = neg_q ? -x_q : x_q;
    yr = neg_q ? -y_q : y_q;
    cr = (xr + 34'sd8192) >>> 14;
    sr = (yr + 34'sd8192) >>> 14;
    cos_o = cr[17:0];
    sin_o = sr[17:0];
  end
endmodule
`default_nettype wire

### rtl/core/eul_matrix.sv
// Coefficient builder: runs CORDIC on the three angles, then forms the nine
// matrix terms one coefficient per cycle. Depends on eul_pkg, eul_cordic.
`default_nettype none
module eul_matrix (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   build_i,
  input  wire logic [15:0]            angle_a_i,
  input  wire logic [15:0]            angle_b_i,
  input  wire logic [15:0]            angle_c_i,
  output logic                        busy_o,
  output eul_pkg::coef_t              coef_o [9]
);
  import eul_pkg::*;

  typedef enum logic [2:0] {
    MS_IDLE, MS_SA, MS_SB, MS_SC, MS_PRE, MS_TERM
  } mstate_e;

  mstate_e st_q, st_d;
  logic cs_start, cs_done;
  logic [15:0] cs_ang;
  logic signed [17:0] cs_sin, cs_cos;
  logic signed [17:0] sa_q, ca_q, sb_q, cb_q, sc_q, cc_q;
  // products sA*sB, cA*sB (Q2.32)
  logic signed [35:0] sasb_q, casb_q;
  logic [4:0] k_q, k_d;
  logic signed [35:0] pa, pb;
  logic signed [17:0] fa, fb;
  logic signed [53:0] term;
  logic signed [53:0] sum;
  logic signed [53:0] rnd;
  coef_t coef_q [9];
  logic [3:0] idx;
  logic cap_pre;

  assign busy_o = (st_q != MS_IDLE) || build_i;
  assign coef_o = coef_q;
  assign cs_ang = (st_d == MS_SA) ? angle_a_i : (st_d == MS_SB) ? angle_b_i : angle_c_i;

  always_comb begin
    st_d = st_q; k_d = k_q; cs_start = 1'b0; cap_pre = 1'b0;
    case (st_q)
      MS_IDLE: if (build_i) begin st_d = MS_SA; cs_start = 1'b1; end
      MS_SA: if (cs_done) begin st_d = MS_SB; cs_start = 1'b1; end
      MS_SB: if (cs_done) begin st_d = MS_SC; cs_start = 1'b1; end
      MS_SC: if (cs_done) st_d = MS_PRE;
      MS_PRE: begin cap_pre = 1'b1; st_d = MS_TERM; k_d = '0; end
      MS_TERM: begin
        k_d = k_q + 5'd1;
        if (k_q == 5'd8) st_d = MS_IDLE;
      end
      default: st_d = MS_IDLE;
    endcase
  end

  eul_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .angle_i(cs_ang),
    .done_o(cs_done), .sin_o(cs_sin), .cos_o(cs_cos)
  );

  // two-factor product for every coefficient, three-factor (pre-product) term for 3, 4, 6, 7
  always_comb begin
    idx = k_q[3:0];
    fa = '0; fb = '0; pa = '0; pb = '0;
    sum = '0;
    case (idx)
      4'd0: begin fa = cb_q; fb = cc_q; end
      4'd1: begin fa = cb_q; fb = sc_q; end
      4'd2: begin fa = -sb_q; fb = 18'sd65536; end
      4'd3: begin fa = -ca_q; fb = sc_q; pa = sasb_q; fb = fb; end
      4'd4: begin fa = ca_q; fb = cc_q; pa = sasb_q; end
      4'd5: begin fa = sa_q; fb = cb_q; end
      4'd6: begin fa = sa_q; fb = sc_q; pa = casb_q; end
      4'd7: begin fa = -sa_q; fb = cc_q; pa = casb_q; end
      4'd8: begin fa = ca_q; fb = cb_q; end
      default: ;
    endcase
    pb = (idx == 4'd3 || idx == 4'd6) ? 36'(cc_q) : 36'(sc_q);
    term = 54'(pa) * 54'(pb);
    sum = (54'(fa) * 54'(fb) <<< 16) + term;
    rnd = (sum + 54'sd2147483648) >>> 32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= MS_IDLE;
      k_q <= '0;
      for (int i = 0; i < 9; i++) coef_q[i] <= (i % 4 == 0) ? 18'sd65536 : 18'sd0;
    end else begin
      st_q <= st_d;
      k_q <= k_d;
      if (st_q == MS_TERM) begin
        if (rnd > 54'sd131071) coef_q[idx] <= 18'sd131071;
        else if (rnd < -54'sd131072) coef_q[idx] <= -18'sd131072;
        else coef_q[idx] <= rnd[17:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cs_done && st_q == MS_SA) begin sa_q <= cs_sin; ca_q <= cs_cos; end
    if (cs_done && st_q == MS_SB) begin sb_q <= cs_sin; cb_q <= cs_cos; end
    if (cs_done && st_q == MS_SC) begin sc_q <= cs_sin; cc_q <= cs_cos; end
    if (cap_pre) begin
      sasb_q <= 36'(sa_q) * 36'(sb_q);
      casb_q <= 36'(ca_q) * 36'(sb_q);
    end
  end
endmodule
`default_nettype wire

### rtl/core/eul_lane.sv
// One output lane: a three-term dot product of a matrix row with the point,
// multiplies registered before the merging add. Depends on eul_pkg.
`default_nettype none
module eul_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire eul_pkg::coef_t                coef_i [3],
  input  wire logic signed [COORD_WIDTH-1:0] pos_i [3],
  output logic signed [COORD_WIDTH:0]        rot_o
);
  import eul_pkg::*;
  localparam int PW = CoefW + COORD_WIDTH;

  logic signed [PW-1:0] prod_q [3];
  logic signed [PW+1:0] acc;
  logic signed [PW+1:0] shf;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) prod_q[k] <= PW'(coef_i[k]) * PW'(pos_i[k]);
  end

  // merge the three products, round and clamp
  always_comb begin
    acc = (PW+2)'(prod_q[0]) + (PW+2)'(prod_q[1]) + (PW+2)'(prod_q[2]);
    shf = (acc + (PW+2)'(32768)) >>> 16;
    if (shf > (PW+2)'((64'sd1 <<< COORD_WIDTH) - 1))
      rot_o = {1'b0, {COORD_WIDTH{1'b1}}};
    else if (shf < -(PW+2)'(64'sd1 <<< COORD_WIDTH))
      rot_o = {1'b1, {COORD_WIDTH{1'b0}}};
    else
      rot_o = shf[COORD_WIDTH:0];
  end
endmodule
`default_nettype wire

### rtl/core/euler_rotation_3d.sv
// Top level of the Euler-angle point rotator.
// Depends on eul_pkg, eul_matrix, eul_lane.
`default_nettype none
// Usage:
//  - Angle registers A, B, C are written over the cfg channel (index 0..2,
//    16-bit angle, full turn = 65536). Indexes beyond 2 are dropped.
//  - Each accepted angle write launches a rebuild of the nine Q1.16
//    coefficients: three CORDIC runs (load plus 19 micro-rotations each)
//    in one shared iterative unit, a pre-product step, then one
//    coefficient per cycle. busy is high and cfg_ready_o low from the write
//    edge until the rebuild ends; no point request and no further write
//    is taken meanwhile.
//  - A point request (start high, busy low) carries pos_x/y/z in Q8.8.
//    Three lanes, one per output row, multiply the point by one matrix row
//    each; the products are registered and then merged, rounded and clamped.
//  - done_o and the rotated point appear together once the point (pos_q)
//    and then the lane products (prod_q) have been registered.
//    Throughput: one point per cycle while the matrix is stable.
//  - The receiver cannot stall; each result appears for one cycle only.
//  - Reset loads the identity matrix and zero angles; nothing is in flight.
module euler_rotation_3d #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z_i,
  output logic                               done_o,
  output logic signed [COORD_WIDTH:0]        rot_x_o,
  output logic signed [COORD_WIDTH:0]        rot_y_o,
  output logic signed [COORD_WIDTH:0]        rot_z_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);
  import eul_pkg::*;

  logic [15:0] ang_a_q, ang_b_q, ang_c_q;
  logic        build_q;
  logic        mat_busy;
  coef_t       coef [9];
  logic signed [COORD_WIDTH-1:0] pos_q [3];
  logic        vld_q, vld2_q;
  logic        acc_in, cfg_wr;
  coef_t       row [3][3];

  // hold off config while a rebuild runs so that every angle write gets its own rebuild
  assign cfg_ready_o = !busy;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;
  assign busy = mat_busy || build_q;
  assign acc_in = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_a_q <= '0; ang_b_q <= '0; ang_c_q <= '0;
      build_q <= 1'b0;
      vld_q <= 1'b0; vld2_q <= 1'b0;
    end else begin
      build_q <= 1'b0;
      if (cfg_wr) begin
        case (cfg_index_i)
          REG_ANGLE_A: begin ang_a_q <= cfg_data_i; build_q <= 1'b1; end
          REG_ANGLE_B: begin ang_b_q <= cfg_data_i; build_q <= 1'b1; end
          REG_ANGLE_C: begin ang_c_q <= cfg_data_i; build_q <= 1'b1; end
          default: ;
        endcase
      end
      vld_q <= acc_in;
      vld2_q <= vld_q;
    end
  end

  // hold the point for the lane multipliers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      pos_q[0] <= pos_x_i; pos_q[1] <= pos_y_i; pos_q[2] <= pos_z_i;
    end
  end

  eul_matrix u_matrix (
    .clk_i, .rst_ni, .build_i(build_q),
    .angle_a_i(ang_a_q), .angle_b_i(ang_b_q), .angle_c_i(ang_c_q),
    .busy_o(mat_busy), .coef_o(coef)
  );

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) row[r][k] = coef[r*3+k];
  end

  eul_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
    .clk_i, .coef_i(row[0]), .pos_i(pos_q), .rot_o(rot_x_o));
  eul_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
    .clk_i, .coef_i(row[1]), .pos_i(pos_q), .rot_o(rot_y_o));
  eul_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
    .clk_i, .coef_i(row[2]), .pos_i(pos_q), .rot_o(rot_z_o));

  assign done_o = vld2_q;
endmodule
`default_nettype wire

### bench/tb_euler_rotation_3d.sv
// Self-checking testbench for euler_rotation_3d: angle writes and point requests,
// each result checked against a built-in fixed-point rotation predictor or, for typed rows, their given result.
// Depends on eul_pkg and the euler_rotation_3d RTL.
`timescale 1ns / 100ps
module tb_euler_rotation_3d;
  import eul_pkg::*;

  localparam int CoordW = 16;
  localparam int Limit = 200000;
  localparam int Phases = 20;
  localparam int PointsPerPhase = 76;
  // Index past the last angle register; the block must drop such writes.
  localparam logic [1:0] RegUnused = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0] rot_t;

  typedef struct {
    rot_t x;
    rot_t y;
    rot_t z;
  } point_res_t;

  typedef struct {
    bit         typed;
    point_res_t res;
  } point_note_t;

  typedef struct {
    bit          is_write;
    logic [1:0]  idx;
    logic [15:0] val;
    coord_t      x;
    coord_t      y;
    coord_t      z;
    bit          typed;
    point_res_t  res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  coord_t      pos_x = '0;
  coord_t      pos_y = '0;
  coord_t      pos_z = '0;
  logic        done_o;
  rot_t        rot_x_o;
  rot_t        rot_y_o;
  rot_t        rot_z_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  euler_rotation_3d #(.COORD_WIDTH(CoordW)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pos_x_i    (pos_x),
    .pos_y_i    (pos_y),
    .pos_z_i    (pos_z),
    .done_o     (done_o),
    .rot_x_o    (rot_x_o),
    .rot_y_o    (rot_y_o),
    .rot_z_o    (rot_z_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Rotation predictor: its own angle registers and Q1.16 matrix.
  // ---------------------------------------------------------------------------
  longint atan_steps [19] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                              41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                              163, 81, 41, 20, 10};
  logic [15:0] ang_a = '0, ang_b = '0, ang_c = '0;
  // Reset holds the exact identity, not the CORDIC value for zero angles.
  longint rot_mat [9] = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // 19-step CORDIC in Q2.30 on a 24-bit turn, folded to [-1/4, 1/4) turn.
  task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
    longint th, x, y, t;
    bit     neg;
    th = longint'(ang) * 256;
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (ang[15:14] == 2'd1 || ang[15:14] == 2'd2) begin
      th -= 64'sd1 << 23;
      neg = 1'b1;
    end else if (ang[15:14] == 2'd3) begin
      th -= 64'sd1 << 24;
    end
    for (int i = 0; i < 19; i++) begin
      if (th >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        th -= atan_steps[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        th += atan_steps[i];
      end
      x = t;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  function automatic longint round_coef(input longint sum48);
    return clamp((sum48 + (64'sd1 << 31)) >>> 32, -131072, 131071);
  endfunction

  task automatic rebuild_matrix();
    longint sa, ca, sb, cb, sc, cc, u;
    u = 65536;
    sin_cos(ang_a, sa, ca);
    sin_cos(ang_b, sb, cb);
    sin_cos(ang_c, sc, cc);
    rot_mat[0] = round_coef(cb * cc * u);
    rot_mat[1] = round_coef(cb * sc * u);
    rot_mat[2] = round_coef(-sb * u * u);
    rot_mat[3] = round_coef(-ca * sc * u + sa * sb * cc);
    rot_mat[4] = round_coef(ca * cc * u + sa * sb * sc);
    rot_mat[5] = round_coef(sa * cb * u);
    rot_mat[6] = round_coef(sa * sc * u + ca * sb * cc);
    rot_mat[7] = round_coef(-sa * cc * u + ca * sb * sc);
    rot_mat[8] = round_coef(ca * cb * u);
  endtask

  task automatic write_angle(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      REG_ANGLE_A: ang_a = val;
      REG_ANGLE_B: ang_b = val;
      REG_ANGLE_C: ang_c = val;
      default: return;
    endcase
    rebuild_matrix();
  endtask

  function automatic point_res_t rotate_point(input coord_t px, input coord_t py,
                                              input coord_t pz);
    point_res_t r;
    longint     p [3];
    longint     v [3];
    p = '{longint'(px), longint'(py), longint'(pz)};
    for (int row = 0; row < 3; row++) begin
      longint acc;
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rot_mat[row * 3 + k] * p[k];
      v[row] = clamp((acc + 32768) >>> 16, -65536, 65535);
    end
    r.x = rot_t'(v[0]);
    r.y = rot_t'(v[1]);
    r.z = rot_t'(v[2]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: queue a prediction (or a typed row's result) on each accepted request, check each strobed result.
  // ---------------------------------------------------------------------------
  point_res_t  pending_rot [$];
  point_note_t typed_notes [$];
  int          errors = 0;
  int          cycles = 0;

  task automatic check_field(input string name, input rot_t exp_v, input rot_t act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rot.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                   $time, rot_x_o, rot_y_o, rot_z_o);
        end else begin
          point_res_t e;
          e = pending_rot.pop_front();
          check_field("rot_x", e.x, rot_x_o);
          check_field("rot_y", e.y, rot_y_o);
          check_field("rot_z", e.z, rot_z_o);
        end
      end
      if (cfg_valid && cfg_ready_o) write_angle(cfg_index, cfg_data);
      if (start && !busy) begin
        point_note_t n;
        n = typed_notes.pop_front();
        pending_rot.push_back(n.typed ? n.res : rotate_point(pos_x, pos_y, pos_z));
      end
    end
  end

  // Hard stop; sized for every point waiting out a full matrix rebuild.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("euler_rotation_3d regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All calls start and return right after a rising edge.
  // ---------------------------------------------------------------------------
  // Hold the request until it is taken; busy is sampled mid-cycle, where it is stable.
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input bit typed, input point_res_t res);
    bit took;
    typed_notes.push_back('{typed, res});
    start <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    do begin
      @(negedge clk_i) took = !busy;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Hold the write until it is taken, then drop cfg_valid and wait for another rising edge before returning.
  task automatic send_write(input logic [1:0] idx, input logic [15:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk_i) took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain every result, then wait the extra edges asked for before a write.
  task automatic drain(input int extra);
    start <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'(16'h8000);
      1: return coord_t'(16'h7fff);
      2: return coord_t'(16'h0000);
      3: return coord_t'(16'hffff);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 3)) << 14;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic stim_row_t pt(input coord_t x, input coord_t y, input coord_t z,
                                   input bit typed);
    stim_row_t r;
    r = '{default: '0};
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    // Typed rows run on the identity matrix: the point passes through unchanged.
    r.res = '{rot_t'(x), rot_t'(y), rot_t'(z)};
    return r;
  endfunction

  function automatic stim_row_t wr(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  stim_row_t directed [$];
  point_res_t no_res = '{default: '0};

  initial begin
    // Identity after reset, then each quadrant, the extremes, a dropped index,
    // and zero angles written back through the CORDIC.
    directed = '{
      pt(16'sd0, 16'sd0, 16'sd0, 1'b1),
      pt(16'sd32767, 16'sd32767, 16'sd32767, 1'b1),
      pt(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1),
      pt(16'sd1, -16'sd1, 16'sd256, 1'b1),
      pt(16'sd32767, -16'sd32768, 16'sd0, 1'b1),
      wr(REG_ANGLE_A, 16'h4000),
      pt(16'sd256, 16'sd512, -16'sd768, 1'b0),
      wr(REG_ANGLE_B, 16'h8000),
      pt(16'sd32767, -16'sd32768, 16'sd1000, 1'b0),
      wr(REG_ANGLE_C, 16'hc000),
      pt(-16'sd32768, 16'sd32767, -16'sd1, 1'b0),
      wr(REG_ANGLE_A, 16'hffff),
      wr(REG_ANGLE_B, 16'hffff),
      wr(REG_ANGLE_C, 16'hffff),
      pt(16'sd32767, -16'sd32768, 16'sd12345, 1'b0),
      wr(RegUnused, 16'h1234),
      pt(16'sd4096, 16'sd4096, 16'sd4096, 1'b0),
      wr(REG_ANGLE_A, 16'h0000),
      wr(REG_ANGLE_B, 16'h0000),
      wr(REG_ANGLE_C, 16'h0000),
      pt(16'sd32767, -16'sd32768, -16'sd1, 1'b0),
      wr(REG_ANGLE_C, 16'h2000),
      pt(16'sd32767, 16'sd32767, 16'sd0, 1'b0),
      pt(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        drain(4);
        send_write(directed[i].idx, directed[i].val);
      end else begin
        send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].typed,
                   directed[i].res);
      end
    end

    // Random phases: new angles while idle, then point bursts, gapped unless quiet.
    for (int ph = 0; ph < Phases; ph++) begin
      bit quiet;
      int left;
      drain(4);
      if (ph % 4 == 3) send_write(RegUnused, 16'($urandom()));
      if ($urandom_range(0, 3) == 0) begin
        send_write(2'($urandom_range(0, 2)), rand_angle());
      end else begin
        send_write(REG_ANGLE_A, rand_angle());
        send_write(REG_ANGLE_B, rand_angle());
        send_write(REG_ANGLE_C, rand_angle());
      end
      quiet = ($urandom_range(0, 3) == 0);
      left = PointsPerPhase;
      while (left > 0) begin
        int burst;
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && left > 0; k++, left--) begin
          send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, no_res);
        end
        if (!quiet) begin
          int gap;
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end

    drain(8);
    if (errors == 0) begin
      $display("euler_rotation_3d regression: pass");
    end else begin
      $display("euler_rotation_3d regression: fail");
    end
    $finish;
  end

endmodule
